// ===== rtl/eush_pkg.sv =====
// Package for the encoder unwrap and stall homing block.
// Holds widths, reset values, register indexes, payload structs and the
// saturation helper. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package eush_pkg;

  localparam int COUNTS_PER_TURN = 8192;
  localparam int ANGLE_W         = $clog2(COUNTS_PER_TURN);
  localparam int HALF_TURN       = COUNTS_PER_TURN / 2;
  localparam int DELTA_W         = ANGLE_W + 2;
  localparam int POS_W           = 40;
  localparam int SPD_W           = 16;
  localparam int CUR_W           = 16;
  localparam int CNT_W           = 8;
  localparam int CUR_LIM_W       = 15;
  localparam int MOVE_W          = 13;
  localparam int STEP_W          = 13;
  localparam int CFG_W           = 15;
  localparam int CFG_IDX_W       = 2;

  localparam logic [CUR_LIM_W-1:0] RST_STALL_CURRENT = CUR_LIM_W'(3190);
  localparam logic [CNT_W-1:0]     RST_STALL_TICKS   = CNT_W'(10);
  localparam logic [MOVE_W-1:0]    RST_STALL_MOVE    = MOVE_W'(17);
  localparam logic [STEP_W-1:0]    RST_RAMP_STEP     = STEP_W'(36);

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STALL_CURRENT = 2'd0,
    REG_STALL_TICKS   = 2'd1,
    REG_STALL_MOVE    = 2'd2,
    REG_RAMP_STEP     = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    CMD_FEEDBACK = 1'b0,
    CMD_HOMING   = 1'b1
  } cmd_e;

  typedef struct packed {
    logic [CUR_LIM_W-1:0] stall_current;
    logic [CNT_W-1:0]     stall_ticks;
    logic [MOVE_W-1:0]    stall_move_counts;
    logic [STEP_W-1:0]    ramp_step_counts;
  } cfg_t;

  typedef struct packed {
    logic                    cmd;
    logic [ANGLE_W-1:0]      rotor_angle;
    logic signed [SPD_W-1:0] raw_speed;
    logic signed [CUR_W-1:0] raw_current;
  } item_t;

  typedef struct packed {
    logic signed [POS_W-1:0] position_counts;
    logic signed [SPD_W-1:0] speed_out;
    logic signed [CUR_W-1:0] current_out;
    logic signed [POS_W-1:0] target_counts;
    logic                    homed;
    logic [CNT_W-1:0]        stall_count;
    logic                    primed;
  } result_t;

  // Clamps a sum one bit wider than the position to the signed position range.
  function automatic logic [POS_W-1:0] sat_fit(input logic [POS_W:0] s);
    logic [POS_W-1:0] r;
    if (s[POS_W] != s[POS_W-1]) begin
      r = s[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
    end else begin
      r = s[POS_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/eush_if.sv =====
// Handshake interfaces for the input item and result channels.
// Depends on eush_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface eush_in_if
  import eush_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic                    cmd;
  logic [ANGLE_W-1:0]      rotor_angle;
  logic signed [SPD_W-1:0] raw_speed;
  logic signed [CUR_W-1:0] raw_current;

  modport source (output valid, output cmd, output rotor_angle, output raw_speed,
                  output raw_current, input ready);
  modport sink   (input valid, input cmd, input rotor_angle, input raw_speed,
                  input raw_current, output ready);
endinterface

interface eush_out_if
  import eush_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] position_counts;
  logic signed [SPD_W-1:0] speed_out;
  logic signed [CUR_W-1:0] current_out;
  logic signed [POS_W-1:0] target_counts;
  logic                    homed;
  logic [CNT_W-1:0]        stall_count;
  logic                    primed;

  modport source (output valid, output position_counts, output speed_out,
                  output current_out, output target_counts, output homed,
                  output stall_count, output primed, input ready);
  modport sink   (input valid, input position_counts, input speed_out,
                  input current_out, input target_counts, input homed,
                  input stall_count, input primed, output ready);
endinterface

`default_nettype wire

// ===== rtl/eush_cfg.sv =====
// Configuration register bank with the four homing thresholds.
// Depends on eush_pkg for the index codes and the cfg_t struct.
`timescale 1ns / 1ps
`default_nettype none

module eush_cfg
  import eush_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i,
  output cfg_t                      cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        REG_STALL_CURRENT: cfg_d.stall_current     = cfg_data_i[CUR_LIM_W-1:0];
        REG_STALL_TICKS:   cfg_d.stall_ticks       = cfg_data_i[CNT_W-1:0];
        REG_STALL_MOVE:    cfg_d.stall_move_counts = cfg_data_i[MOVE_W-1:0];
        REG_RAMP_STEP:     cfg_d.ramp_step_counts  = cfg_data_i[STEP_W-1:0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.stall_current     <= RST_STALL_CURRENT;
      cfg_q.stall_ticks       <= RST_STALL_TICKS;
      cfg_q.stall_move_counts <= RST_STALL_MOVE;
      cfg_q.ramp_step_counts  <= RST_RAMP_STEP;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== rtl/eush_core.sv =====
// Unwrap and homing state, updated when a transaction is accepted.
// Depends on eush_pkg for the item, result and configuration structs.
`timescale 1ns / 1ps
`default_nettype none

module eush_core
  import eush_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  accept_i,
  input  wire item_t item_i,
  input  wire cfg_t  cfg_i,
  output result_t    result_o
);

  localparam logic signed [DELTA_W-1:0] HALF_S = DELTA_W'(HALF_TURN);
  localparam logic signed [DELTA_W-1:0] TURN_S = DELTA_W'(COUNTS_PER_TURN);

  logic                    primed_q, primed_d;
  logic [ANGLE_W-1:0]      last_q, last_d;
  logic [POS_W-1:0]        pos_q, pos_d;
  logic [SPD_W-1:0]        spd_q, spd_d;
  logic [CUR_W-1:0]        cur_q, cur_d;
  logic [CNT_W-1:0]        cnt_q, cnt_d;
  logic [POS_W-1:0]        ramp_q, ramp_d;
  logic [POS_W-1:0]        ref_q, ref_d;
  logic                    homed_q, homed_d;

  logic signed [DELTA_W-1:0] diff_raw, delta;
  logic [POS_W:0]            pos_sum, ramp_sum, pos_diff, pos_abs;
  logic [CUR_W:0]            cur_ext, cur_mag;
  logic                      pushing, still;
  logic [CNT_W-1:0]          cnt_next;

  always_comb begin
    diff_raw = $signed({2'b00, item_i.rotor_angle}) - $signed({2'b00, last_q});
    if (diff_raw > HALF_S) begin
      delta = diff_raw - TURN_S;
    end else if (diff_raw < -HALF_S) begin
      delta = diff_raw + TURN_S;
    end else begin
      delta = diff_raw;
    end
    pos_sum = {pos_q[POS_W-1], pos_q} + (POS_W + 1)'(delta);

    cur_ext = {cur_q[CUR_W-1], cur_q};
    cur_mag = cur_ext[CUR_W] ? (~cur_ext + 1'b1) : cur_ext;
    pushing = cur_mag > {{(CUR_W + 1 - CUR_LIM_W){1'b0}}, cfg_i.stall_current};

    pos_diff = {pos_q[POS_W-1], pos_q} - {ref_q[POS_W-1], ref_q};
    pos_abs  = pos_diff[POS_W] ? (~pos_diff + 1'b1) : pos_diff;
    still    = pos_abs < {{(POS_W + 1 - MOVE_W){1'b0}}, cfg_i.stall_move_counts};

    if (pushing && still) begin
      cnt_next = (cnt_q == CNT_MAX) ? CNT_MAX : cnt_q + 1'b1;
    end else begin
      cnt_next = '0;
    end
    ramp_sum = {ramp_q[POS_W-1], ramp_q}
             - {{(POS_W + 1 - STEP_W){1'b0}}, cfg_i.ramp_step_counts};

    primed_d = primed_q;
    last_d   = last_q;
    pos_d    = pos_q;
    spd_d    = spd_q;
    cur_d    = cur_q;
    cnt_d    = cnt_q;
    ramp_d   = ramp_q;
    ref_d    = ref_q;
    homed_d  = homed_q;

    if (item_i.cmd == CMD_FEEDBACK) begin
      spd_d  = item_i.raw_speed;
      last_d = item_i.rotor_angle;
      if (!primed_q) begin
        primed_d = 1'b1;
      end else begin
        pos_d = sat_fit(pos_sum);
        cur_d = item_i.raw_current;
      end
    end else begin
      if (cnt_next < cfg_i.stall_ticks) begin
        cnt_d  = cnt_next;
        ramp_d = sat_fit(ramp_sum);
        ref_d  = pos_q;
      end else begin
        cnt_d   = '0;
        pos_d   = '0;
        ramp_d  = '0;
        ref_d   = '0;
        homed_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      primed_q <= 1'b0;
      last_q   <= '0;
      pos_q    <= '0;
      spd_q    <= '0;
      cur_q    <= '0;
      cnt_q    <= '0;
      ramp_q   <= '0;
      ref_q    <= '0;
      homed_q  <= 1'b0;
    end else if (accept_i) begin
      primed_q <= primed_d;
      last_q   <= last_d;
      pos_q    <= pos_d;
      spd_q    <= spd_d;
      cur_q    <= cur_d;
      cnt_q    <= cnt_d;
      ramp_q   <= ramp_d;
      ref_q    <= ref_d;
      homed_q  <= homed_d;
    end
  end

  always_comb begin
    result_o.position_counts = pos_d;
    result_o.speed_out       = spd_d;
    result_o.current_out     = cur_d;
    result_o.target_counts   = ramp_d;
    result_o.homed           = homed_d;
    result_o.stall_count     = cnt_d;
    result_o.primed          = primed_d;
  end

endmodule

`default_nettype wire

// ===== rtl/eush_skid.sv =====
// Two-entry result buffer that decouples the input side from a stalled sink.
// Depends on eush_pkg for the result_t struct.
`timescale 1ns / 1ps
`default_nettype none

module eush_skid
  import eush_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    push_i,
  input  wire result_t data_i,
  output logic         ready_o,
  output logic         valid_o,
  output result_t      data_o,
  input  wire logic    pop_ready_i
);

  logic    valid0_q, valid0_d, valid1_q, valid1_d;
  result_t slot0_q, slot0_d, slot1_q, slot1_d;
  logic    pop;

  always_comb begin
    pop      = valid0_q && pop_ready_i;
    valid0_d = valid0_q;
    valid1_d = valid1_q;
    slot0_d  = slot0_q;
    slot1_d  = slot1_q;
    if (pop) begin
      if (valid1_q) begin
        slot0_d  = slot1_q;
        valid1_d = push_i;
        slot1_d  = data_i;
      end else begin
        slot0_d  = data_i;
        valid0_d = push_i;
      end
    end else if (push_i) begin
      if (!valid0_q) begin
        slot0_d  = data_i;
        valid0_d = 1'b1;
      end else begin
        slot1_d  = data_i;
        valid1_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid0_q <= 1'b0;
      valid1_q <= 1'b0;
    end else begin
      valid0_q <= valid0_d;
      valid1_q <= valid1_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot0_q <= slot0_d;
    slot1_q <= slot1_d;
  end

  assign ready_o = !valid1_q;
  assign valid_o = valid0_q;
  assign data_o  = slot0_q;

endmodule

`default_nettype wire

// ===== rtl/encoder_unwrap_stall_homing.sv =====
// Top level of the multi-turn encoder unwrap with stall homing.
// Depends on eush_pkg, eush_if, eush_cfg, eush_core and eush_skid.
//
// The input channel carries either a feedback frame (cmd low) with the
// single-turn angle, speed and current, or a homing tick (cmd high). Every
// input transaction yields exactly one result transaction on the output
// channel with the position, target, last speed and current, the stall
// count and the homed and primed flags.
// The state update for a transaction happens in the cycle it is accepted,
// and its result is registered in the result buffer before it is offered.
// One transaction can be accepted every cycle while the result buffer has
// room; the position add and compare logic lies in a single register stage.
// A two-entry result buffer lets a transaction be accepted while an earlier
// result is still waiting; ready drops only once both entries are full and
// rises again in the cycle after the sink takes a result.
// The configuration port writes one threshold register per enabled cycle and
// must be written only while no transaction is in flight; this is not enforced.
// Reset clears all tracking state and the buffer and restores the default
// thresholds; the block is ready as soon as reset is released.
`timescale 1ns / 1ps
`default_nettype none

module encoder_unwrap_stall_homing
  import eush_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  eush_in_if.sink                   in_i,
  eush_out_if.source                out_o,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i
);

  cfg_t    cfg;
  item_t   item;
  result_t result;
  result_t head;
  logic    skid_ready;
  logic    accept;

  assign item.cmd         = in_i.cmd;
  assign item.rotor_angle = in_i.rotor_angle;
  assign item.raw_speed   = in_i.raw_speed;
  assign item.raw_current = in_i.raw_current;

  assign in_i.ready = skid_ready;
  assign accept     = in_i.valid && skid_ready;

  eush_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  eush_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .item_i   (item),
    .cfg_i    (cfg),
    .result_o (result)
  );

  eush_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .data_i      (result),
    .ready_o     (skid_ready),
    .valid_o     (out_o.valid),
    .data_o      (head),
    .pop_ready_i (out_o.ready)
  );

  assign out_o.position_counts = head.position_counts;
  assign out_o.speed_out       = head.speed_out;
  assign out_o.current_out     = head.current_out;
  assign out_o.target_counts   = head.target_counts;
  assign out_o.homed           = head.homed;
  assign out_o.stall_count     = head.stall_count;
  assign out_o.primed          = head.primed;

endmodule

`default_nettype wire
